// ----- rtl/mvrf_pkg.sv -----
// ----------------------------------------------------------------------------
// mvrf_pkg
// Shared types, codes and constants of the minor variant read filter.
// ----------------------------------------------------------------------------
package mvrf_pkg;

	// Default sizes handed to the top level parameters.
	localparam int REF_DEPTH_DEF  = 65536;
	localparam int COUNT_BITS_DEF = 24;

	// Fixed field widths of the request and result items.
	localparam int CNT_W    = 24;
	localparam int KEPT_W   = 25;
	localparam int POS_W    = 16;
	localparam int MASK_W   = 4;
	localparam int FLAG_W   = 17;
	localparam int CURSOR_W = 17;
	localparam int SAT_W    = 16;
	localparam int QUAL_W   = 7;
	localparam int BASE_W   = 8;
	localparam int SUP_W    = 17;
	localparam int VAR_W    = 20;
	localparam int RLEN_W   = 17;
	localparam int CFG_W    = 20;

	localparam logic [FLAG_W-1:0]   FLAG_MAX   = 17'd65536;
	localparam logic [CURSOR_W-1:0] CURSOR_MAX = 17'h1FFFF;
	localparam logic [SAT_W-1:0]    SAT_MAX    = 16'hFFFF;

	// Register reset values.
	localparam logic [SUP_W-1:0]  MIN_SUPPORT_RST = 17'd6554;
	localparam logic [VAR_W-1:0]  MIN_VARIANT_RST = 20'd13107;
	localparam logic [QUAL_W-1:0] MIN_QUALITY_RST = 7'd7;
	localparam logic [RLEN_W-1:0] REF_LENGTH_RST  = 17'd0;

	// Letters after case folding, and the fold mask.
	localparam logic [BASE_W-1:0] FOLD_MASK = 8'hDF;
	localparam logic [BASE_W-1:0] CHAR_A    = 8'h41;
	localparam logic [BASE_W-1:0] CHAR_C    = 8'h43;
	localparam logic [BASE_W-1:0] CHAR_G    = 8'h47;
	localparam logic [BASE_W-1:0] CHAR_T    = 8'h54;

	typedef enum logic [1:0] {
		KIND_PROFILE = 2'd0,
		KIND_START   = 2'd1,
		KIND_BASE    = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_MATCH = 2'd0,
		OP_INS   = 2'd1,
		OP_DEL   = 2'd2,
		OP_CLIP  = 2'd3
	} cigar_op_t;

	typedef enum logic [1:0] {
		CFG_MIN_SUPPORT = 2'd0,
		CFG_MIN_VARIANT = 2'd1,
		CFG_MIN_QUALITY = 2'd2,
		CFG_REF_LENGTH  = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROF,
		ST_BASE,
		ST_VWAIT,
		ST_VOUT
	} state_t;

	// Status returned by the read verdict unit.
	typedef struct packed {
		logic done;
		logic keep;
	} vrd_status_t;

	function automatic logic [SAT_W-1:0] sat_inc16(input logic [SAT_W-1:0] v);
		return (v < SAT_MAX) ? v + 16'd1 : SAT_MAX;
	endfunction

endpackage

// ----- rtl/mvrf_ram.sv -----
// ----------------------------------------------------------------------------
// mvrf_ram
// Simple dual port synchronous RAM holding the per-position variant masks.
// ----------------------------------------------------------------------------
module mvrf_ram #(
	parameter int DEPTH = mvrf_pkg::REF_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [mvrf_pkg::MASK_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [mvrf_pkg::MASK_W-1:0] rdata
);

	logic [mvrf_pkg::MASK_W-1:0] mem [DEPTH];
	logic [mvrf_pkg::MASK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read so the consumer may wait.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mvrf_mask.sv -----
// ----------------------------------------------------------------------------
// mvrf_mask
// Builds the minor variant mask of one profile position in two steps:
// the support threshold product is registered, then the counts are compared.
// ----------------------------------------------------------------------------
module mvrf_mask #(
	parameter int COUNT_BITS = mvrf_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               load,
	input  logic [mvrf_pkg::CNT_W-1:0]         count_a,
	input  logic [mvrf_pkg::CNT_W-1:0]         count_c,
	input  logic [mvrf_pkg::CNT_W-1:0]         count_g,
	input  logic [mvrf_pkg::CNT_W-1:0]         count_t,
	input  logic signed [mvrf_pkg::KEPT_W-1:0] kept_count,
	input  logic [mvrf_pkg::SUP_W-1:0]         min_support,
	output logic [mvrf_pkg::MASK_W-1:0]        mask
);

	localparam int CB     = (COUNT_BITS < mvrf_pkg::CNT_W) ? COUNT_BITS : mvrf_pkg::CNT_W;
	localparam int PROD_W = mvrf_pkg::SUP_W + mvrf_pkg::CNT_W;
	localparam logic [mvrf_pkg::CNT_W-1:0] CNT_MASK =
		mvrf_pkg::CNT_W'((64'd1 << CB) - 64'd1);

	logic [mvrf_pkg::CNT_W-1:0] cnt_s1 [mvrf_pkg::MASK_W];
	logic                       none_s1;
	logic [PROD_W-1:0]          prod_s1;
	logic [mvrf_pkg::CNT_W-1:0] best;

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_s1[0] <= count_a & CNT_MASK;
			cnt_s1[1] <= count_c & CNT_MASK;
			cnt_s1[2] <= count_g & CNT_MASK;
			cnt_s1[3] <= count_t & CNT_MASK;
			// A negative or zero kept count means no coverage.
			none_s1   <= kept_count[mvrf_pkg::KEPT_W-1] || (kept_count == '0);
			prod_s1   <= PROD_W'(min_support) * PROD_W'(kept_count[mvrf_pkg::CNT_W-1:0]);
		end
	end

	always_comb begin
		best = cnt_s1[0];
		for (int i = 1; i < mvrf_pkg::MASK_W; i++) begin
			if (cnt_s1[i] > best) begin
				best = cnt_s1[i];
			end
		end
		for (int i = 0; i < mvrf_pkg::MASK_W; i++) begin
			mask[i] = !none_s1 && (cnt_s1[i] < best) &&
			          (PROD_W'({cnt_s1[i], 16'h0000}) >= prod_s1);
		end
	end

endmodule

// ----- rtl/mvrf_verdict.sv -----
// ----------------------------------------------------------------------------
// mvrf_verdict
// Three stage cross-multiply compare that decides whether a read is kept.
// ----------------------------------------------------------------------------
module mvrf_verdict (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mvrf_pkg::SAT_W-1:0]    hits,
	input  logic [mvrf_pkg::SAT_W-1:0]    mapped,
	input  logic [mvrf_pkg::POS_W-1:0]    aligned_length,
	input  logic [mvrf_pkg::RLEN_W-1:0]   reference_length,
	input  logic [mvrf_pkg::VAR_W-1:0]    min_variant,
	output mvrf_pkg::vrd_status_t         status
);

	localparam int L1_W = mvrf_pkg::SAT_W + mvrf_pkg::RLEN_W;
	localparam int M1_W = mvrf_pkg::SAT_W + mvrf_pkg::POS_W;
	localparam int L2_W = L1_W + 16;
	localparam int R2_W = M1_W + mvrf_pkg::VAR_W;

	logic              v_s1, v_s2, v_s3;
	logic [L1_W-1:0]   lhs_s1;
	logic [M1_W-1:0]   ml_s1;
	logic [L2_W-1:0]   lhs_s2;
	logic [R2_W-1:0]   rhs_s2;
	logic              keep_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		lhs_s1  <= L1_W'(hits) * L1_W'(reference_length);
		ml_s1   <= M1_W'(mapped) * M1_W'(aligned_length);
		lhs_s2  <= {lhs_s1, 16'h0000};
		rhs_s2  <= R2_W'(min_variant) * R2_W'(ml_s1);
		// The read is dropped when its weighted share exceeds the limit.
		keep_s3 <= !(R2_W'(lhs_s2) > rhs_s2);
	end

	assign status.done = v_s3;
	assign status.keep = keep_s3;

endmodule

// ----- rtl/minor_variant_read_filter_unit.sv -----
// ----------------------------------------------------------------------------
// minor_variant_read_filter_unit
// Flags minor variant bases per reference position and filters reads that
// carry too many of them.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tdata fields, s_tuser = kind
//  m_*       out        m_tvalid/m_tready  m_tdata fields, m_tuser = result_kind
//  cfg_*     in         cfg_wen            cfg_index, cfg_data
//
//  After reset a clearing pass writes zero to all REF_DEPTH mask entries,
//  one per cycle; no request is taken until the clearing pass is done.
//  A profile request and a read base wait for the mask memory read, a read
//  end for the three stage multiply compare unit.
//  A request is taken while a result still waits in the output register;
//  only a request that itself makes a result waits for that register to free.
//
module minor_variant_read_filter_unit #(
	parameter int REF_DEPTH  = mvrf_pkg::REF_DEPTH_DEF,
	parameter int COUNT_BITS = mvrf_pkg::COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// position, count_a, count_c, count_g, count_t, kept_count, has_quality,
	// aligned_length, cigar_op, base, quality, zero fill
	input  logic [175:0] s_tdata,
	// kind
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// variant_mask, flagged_positions, keep_read, read_variants,
	// mapped_variants, zero fill
	output logic [55:0]  m_tdata,
	// result_kind
	output logic         m_tuser,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_index,
	input  logic [mvrf_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(REF_DEPTH);
	localparam logic [27:0] DEPTH_W = 28'(REF_DEPTH);
	localparam logic [20:0] DEPTH_C = 21'(REF_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(REF_DEPTH - 1);

	// Request field views.
	logic [mvrf_pkg::POS_W-1:0]         in_position;
	logic [mvrf_pkg::CNT_W-1:0]         in_count_a, in_count_c, in_count_g, in_count_t;
	logic signed [mvrf_pkg::KEPT_W-1:0] in_kept_count;
	logic                               in_has_quality;
	logic [mvrf_pkg::POS_W-1:0]         in_aligned_length;
	logic [1:0]                         in_cigar_op;
	logic [mvrf_pkg::BASE_W-1:0]        in_base;
	logic [mvrf_pkg::QUAL_W-1:0]        in_quality;
	mvrf_pkg::kind_t                    in_kind;

	assign in_position       = s_tdata[15:0];
	assign in_count_a        = s_tdata[39:16];
	assign in_count_c        = s_tdata[63:40];
	assign in_count_g        = s_tdata[87:64];
	assign in_count_t        = s_tdata[111:88];
	assign in_kept_count     = s_tdata[136:112];
	assign in_has_quality    = s_tdata[137];
	assign in_aligned_length = s_tdata[153:138];
	assign in_cigar_op       = s_tdata[155:154];
	assign in_base           = s_tdata[163:156];
	assign in_quality        = s_tdata[170:164];
	assign in_kind           = mvrf_pkg::kind_t'(s_tuser);

	// Configuration registers.
	logic [mvrf_pkg::SUP_W-1:0]  min_support_q;
	logic [mvrf_pkg::VAR_W-1:0]  min_variant_q;
	logic [mvrf_pkg::QUAL_W-1:0] min_quality_q;
	logic [mvrf_pkg::RLEN_W-1:0] ref_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_support_q <= mvrf_pkg::MIN_SUPPORT_RST;
			min_variant_q <= mvrf_pkg::MIN_VARIANT_RST;
			min_quality_q <= mvrf_pkg::MIN_QUALITY_RST;
			ref_length_q  <= mvrf_pkg::REF_LENGTH_RST;
		end else if (cfg_wen) begin
			unique case (mvrf_pkg::cfg_index_t'(cfg_index))
				mvrf_pkg::CFG_MIN_SUPPORT: min_support_q <= cfg_data[16:0];
				mvrf_pkg::CFG_MIN_VARIANT: min_variant_q <= cfg_data;
				mvrf_pkg::CFG_MIN_QUALITY: min_quality_q <= cfg_data[6:0];
				mvrf_pkg::CFG_REF_LENGTH:  ref_length_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Control and read state.
	mvrf_pkg::state_t state_q, state_nx;
	logic [AW-1:0]                 clr_addr_q;
	logic [mvrf_pkg::FLAG_W-1:0]   flagged_q;
	logic [mvrf_pkg::CURSOR_W-1:0] cursor_q;
	logic [mvrf_pkg::SAT_W-1:0]    hits_q, mapped_q;
	logic [mvrf_pkg::POS_W-1:0]    aligned_q;
	logic                          qual_present_q;
	logic                          clipped_q;
	logic                          m_tvalid_q;

	// Payload registers.
	logic [AW-1:0]                 idx_s1;
	mvrf_pkg::cigar_op_t           op_s1;
	logic [mvrf_pkg::BASE_W-1:0]   base_s1;
	logic [mvrf_pkg::QUAL_W-1:0]   qual_s1;
	logic                          keep_q;
	logic [55:0]                   m_tdata_q;
	logic                          m_tuser_q;

	// Control outputs.
	logic                          accept;
	logic                          out_free;
	logic                          ram_we, ram_re;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [mvrf_pkg::MASK_W-1:0]   ram_wdata, ram_rdata;
	logic                          mask_load;
	logic                          vrd_start;
	logic                          commit_prof, commit_end;
	mvrf_pkg::vrd_status_t         vrd_status;

	logic [AW-1:0]                 pos_idx;
	logic [AW-1:0]                 cursor_addr;
	logic [mvrf_pkg::MASK_W-1:0]   new_mask;
	logic [mvrf_pkg::FLAG_W-1:0]   flagged_nx;
	logic [mvrf_pkg::CURSOR_W-1:0] cursor_nx;
	logic [mvrf_pkg::SAT_W-1:0]    hits_nx, mapped_nx;
	logic                          clipped_nx;

	assign out_free    = !m_tvalid_q || m_tready;
	assign cursor_addr = AW'(cursor_q);

	// Position modulo the store depth by conditional subtraction of
	// shifted copies of the depth; positions are under 256 times the depth.
	always_comb begin
		logic [27:0] rem;
		rem = 28'(in_position);
		for (int k = 7; k >= 0; k--) begin
			if (rem >= (DEPTH_W << k)) begin
				rem = rem - (DEPTH_W << k);
			end
		end
		pos_idx = AW'(rem);
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mvrf_pkg::ST_CLEAR: begin
				if (clr_addr_q == CLR_LAST) begin
					state_nx = mvrf_pkg::ST_IDLE;
				end
			end
			mvrf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_kind)
						mvrf_pkg::KIND_PROFILE: state_nx = mvrf_pkg::ST_PROF;
						mvrf_pkg::KIND_START:   state_nx = mvrf_pkg::ST_IDLE;
						mvrf_pkg::KIND_BASE:    state_nx = mvrf_pkg::ST_BASE;
						mvrf_pkg::KIND_END:     state_nx = mvrf_pkg::ST_VWAIT;
						default:                state_nx = mvrf_pkg::ST_IDLE;
					endcase
				end
			end
			mvrf_pkg::ST_PROF: begin
				if (out_free) begin
					state_nx = mvrf_pkg::ST_IDLE;
				end
			end
			mvrf_pkg::ST_BASE: state_nx = mvrf_pkg::ST_IDLE;
			mvrf_pkg::ST_VWAIT: begin
				if (vrd_status.done) begin
					state_nx = mvrf_pkg::ST_VOUT;
				end
			end
			mvrf_pkg::ST_VOUT: begin
				if (out_free) begin
					state_nx = mvrf_pkg::ST_IDLE;
				end
			end
			default: state_nx = mvrf_pkg::ST_CLEAR;
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		s_tready    = (state_q == mvrf_pkg::ST_IDLE);
		accept      = s_tready && s_tvalid;
		ram_re      = accept && (in_kind == mvrf_pkg::KIND_PROFILE ||
		                         in_kind == mvrf_pkg::KIND_BASE);
		ram_raddr   = (in_kind == mvrf_pkg::KIND_PROFILE) ? pos_idx : cursor_addr;
		mask_load   = accept && (in_kind == mvrf_pkg::KIND_PROFILE);
		vrd_start   = accept && (in_kind == mvrf_pkg::KIND_END);
		commit_prof = (state_q == mvrf_pkg::ST_PROF) && out_free;
		commit_end  = (state_q == mvrf_pkg::ST_VOUT) && out_free;
		ram_we      = 1'b0;
		ram_waddr   = idx_s1;
		ram_wdata   = new_mask;
		if (state_q == mvrf_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (commit_prof) begin
			ram_we    = 1'b1;
		end
	end

	// Flagged position count: the old mask leaves, the new one enters.
	always_comb begin
		flagged_nx = flagged_q;
		if ((ram_rdata != '0) && (flagged_nx != '0)) begin
			flagged_nx = flagged_nx - 17'd1;
		end
		if ((new_mask != '0) && (flagged_nx < mvrf_pkg::FLAG_MAX)) begin
			flagged_nx = flagged_nx + 17'd1;
		end
	end

	// Read base update.
	always_comb begin
		logic [mvrf_pkg::MASK_W-1:0] m;
		logic [mvrf_pkg::MASK_W-1:0] bit_sel;
		logic [mvrf_pkg::BASE_W-1:0] b;
		logic                        adv;
		cursor_nx  = cursor_q;
		hits_nx    = hits_q;
		mapped_nx  = mapped_q;
		clipped_nx = clipped_q;
		adv        = 1'b0;
		b          = base_s1 & mvrf_pkg::FOLD_MASK;
		m          = (21'(cursor_q) < DEPTH_C) ? ram_rdata : '0;
		unique case (b)
			mvrf_pkg::CHAR_A: bit_sel = 4'b0001;
			mvrf_pkg::CHAR_C: bit_sel = 4'b0010;
			mvrf_pkg::CHAR_G: bit_sel = 4'b0100;
			mvrf_pkg::CHAR_T: bit_sel = 4'b1000;
			default:          bit_sel = 4'b0000;
		endcase
		if (!clipped_q) begin
			unique case (op_s1)
				mvrf_pkg::OP_CLIP: clipped_nx = 1'b1;
				mvrf_pkg::OP_INS:  ;
				mvrf_pkg::OP_DEL:  adv = 1'b1;
				mvrf_pkg::OP_MATCH: begin
					adv = 1'b1;
					// Low quality bases only move the cursor.
					if (!(qual_present_q && (qual_s1 < min_quality_q)) &&
					    (m != '0) && (bit_sel != '0)) begin
						if ((m & bit_sel) != '0) begin
							hits_nx = mvrf_pkg::sat_inc16(hits_q);
						end
						mapped_nx = mvrf_pkg::sat_inc16(mapped_q);
					end
				end
				default: ;
			endcase
		end
		if (adv && (cursor_q < mvrf_pkg::CURSOR_MAX)) begin
			cursor_nx = cursor_q + 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mvrf_pkg::ST_CLEAR;
			clr_addr_q     <= '0;
			flagged_q      <= '0;
			cursor_q       <= '0;
			hits_q         <= '0;
			mapped_q       <= '0;
			aligned_q      <= '0;
			qual_present_q <= 1'b0;
			clipped_q      <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == mvrf_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (accept && (in_kind == mvrf_pkg::KIND_START)) begin
				cursor_q       <= mvrf_pkg::CURSOR_W'(in_position);
				qual_present_q <= in_has_quality;
				aligned_q      <= in_aligned_length;
				hits_q         <= '0;
				mapped_q       <= '0;
				clipped_q      <= 1'b0;
			end
			if (state_q == mvrf_pkg::ST_BASE) begin
				cursor_q  <= cursor_nx;
				hits_q    <= hits_nx;
				mapped_q  <= mapped_nx;
				clipped_q <= clipped_nx;
			end
			if (commit_prof) begin
				flagged_q <= flagged_nx;
			end
			if (commit_prof || commit_end) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= pos_idx;
			op_s1   <= mvrf_pkg::cigar_op_t'(in_cigar_op);
			base_s1 <= in_base;
			qual_s1 <= in_quality;
		end
		if ((state_q == mvrf_pkg::ST_VWAIT) && vrd_status.done) begin
			keep_q <= vrd_status.keep;
		end
		if (commit_prof) begin
			m_tuser_q <= 1'b0;
			m_tdata_q <= {35'd0, flagged_nx, new_mask};
		end else if (commit_end) begin
			m_tuser_q <= 1'b1;
			m_tdata_q <= {2'd0, mapped_q, hits_q, keep_q, 17'd0, 4'd0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	mvrf_ram #(
		.DEPTH (REF_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mvrf_mask #(
		.COUNT_BITS (COUNT_BITS)
	) u_mask (
		.clk         (clk),
		.load        (mask_load),
		.count_a     (in_count_a),
		.count_c     (in_count_c),
		.count_g     (in_count_g),
		.count_t     (in_count_t),
		.kept_count  (in_kept_count),
		.min_support (min_support_q),
		.mask        (new_mask)
	);

	mvrf_verdict u_verdict (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (vrd_start),
		.hits             (hits_q),
		.mapped           (mapped_q),
		.aligned_length   (aligned_q),
		.reference_length (ref_length_q),
		.min_variant      (min_variant_q),
		.status           (vrd_status)
	);

endmodule
